/* rtl/core/swcc_pkg.sv */
// Shared types, codes and CRC-8 functions for the sensor word CRC codec.
package swcc_pkg;

    localparam logic       OP_RECEIVE   = 1'b0;
    localparam logic       OP_ENCODE    = 1'b1;

    localparam logic [7:0] CRC_POLY     = 8'h31;
    localparam logic [7:0] CRC_INIT     = 8'hFF;
    localparam logic [7:0] BYTE_INVALID = 8'hFF;
    localparam logic [7:0] PERCENT_FULL = 8'd100;

    typedef struct packed {
        logic [15:0] word_value;
        logic [7:0]  crc_value;
        logic        crc_error;
        logic        frame_error;
    } swcc_result_t;

    // One byte through the MSB-first CRC-8 shift register.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (r[7]) begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] word_crc(input logic [7:0] hi, input logic [7:0] lo);
        return crc_feed(crc_feed(CRC_INIT, hi), lo);
    endfunction

endpackage

/* rtl/core/sensor_word_crc_codec.sv */
// An accepted word passes through the input register and then the result register.
// Throughput: one word per cycle; the input register and the result register form a
// two-stage pipeline that moves whenever the result register is empty or being taken.
// Receive bytes that do not complete a triplet give no result word.
// Reset (aresetn low, synchronous) empties both stages and clears the receive position
// and the sticky frame error.
module sensor_word_crc_codec
    import swcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] ref_value
    input  logic [1:0]  s_tuser,   // [0] operation, [1] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] word_value, [23:16] crc_value
    output logic [1:0]  m_tuser    // [0] crc_error, [1] frame_error
);

    logic         stg_valid_reg;
    logic         stg_op_reg;
    logic [7:0]   stg_rx_reg;
    logic         stg_start_reg;
    logic [7:0]   stg_ref_reg;
    logic         out_valid_reg;
    swcc_result_t out_reg;

    logic         out_ready;
    logic         stg_take;
    logic         s_accept;
    logic         rx_take;
    logic         rx_has_result;
    swcc_result_t rx_result;
    swcc_result_t enc_result;
    logic         produce;
    swcc_result_t sel_result;

    assign out_ready = !out_valid_reg || m_tready;
    assign stg_take  = stg_valid_reg && out_ready;
    assign s_tready  = !stg_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign rx_take   = stg_take && (stg_op_reg == OP_RECEIVE);

    swcc_rx_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (rx_take),
        .rx_byte     (stg_rx_reg),
        .frame_start (stg_start_reg),
        .has_result  (rx_has_result),
        .result      (rx_result)
    );

    swcc_encoder u_encoder (
        .ref_value (stg_ref_reg),
        .result    (enc_result)
    );

    always_comb begin
        if (stg_op_reg == OP_ENCODE) begin
            produce    = 1'b1;
            sel_result = enc_result;
        end else begin
            produce    = rx_has_result;
            sel_result = rx_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (s_accept) begin
            stg_valid_reg <= 1'b1;
        end else if (stg_take) begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stg_op_reg    <= s_tuser[0];
            stg_start_reg <= s_tuser[1];
            stg_rx_reg    <= s_tdata[7:0];
            stg_ref_reg   <= s_tdata[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stg_take && produce) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_take && produce) begin
            out_reg <= sel_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.crc_value, out_reg.word_value};
    assign m_tuser  = {out_reg.frame_error, out_reg.crc_error};

endmodule

/* rtl/core/swcc_encoder.sv */
// Percent-to-ticks scaler with saturation and CRC for the encode direction.
module swcc_encoder
    import swcc_pkg::*;
(
    input  logic [7:0]   ref_value,
    output swcc_result_t result
);

    // ticks = v*65535/100 = v*655 + floor(v*35/100).
    // floor(y/100) for y <= 3500 is (y*5243) >> 19; 35*5243 = 183505.
    localparam logic [17:0] FRAC_MULT  = 18'd183505;
    localparam int          FRAC_SHIFT = 19;
    localparam logic [9:0]  WHOLE_MULT = 10'd655;

    logic [25:0] frac_prod;
    logic [6:0]  frac_part;
    logic [17:0] whole_part;
    logic [17:0] ticks_sum;
    logic [15:0] ticks;

    always_comb begin
        frac_prod  = 26'(ref_value) * 26'(FRAC_MULT);
        frac_part  = frac_prod[FRAC_SHIFT +: 7];
        whole_part = 18'(ref_value) * 18'(WHOLE_MULT);
        ticks_sum  = whole_part + 18'(frac_part);
        if (ref_value > PERCENT_FULL) begin
            ticks = 16'hFFFF;
        end else begin
            ticks = ticks_sum[15:0];
        end
        result.word_value  = ticks;
        result.crc_value   = word_crc(ticks[15:8], ticks[7:0]);
        result.crc_error   = 1'b0;
        result.frame_error = 1'b0;
    end

endmodule

/* rtl/core/swcc_rx_framer.sv */
// Receive-side triplet framer: holds word bytes, checks the CRC, tracks sticky error.
module swcc_rx_framer
    import swcc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         take,
    input  logic [7:0]   rx_byte,
    input  logic         frame_start,
    output logic         has_result,
    output swcc_result_t result
);

    localparam logic [1:0] POS_HIGH = 2'd0;
    localparam logic [1:0] POS_LOW  = 2'd1;
    localparam logic [1:0] POS_CRC  = 2'd2;

    logic [1:0] pos_reg, pos_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;
    logic       sticky_reg, sticky_next;
    logic [1:0] pos_eff;
    logic       sticky_eff;
    logic [7:0] crc_calc;
    logic       err;

    always_comb begin
        pos_eff    = frame_start ? POS_HIGH : pos_reg;
        sticky_eff = frame_start ? 1'b0 : sticky_reg;
        crc_calc   = word_crc(high_reg, low_reg);
        // A byte of all ones means the sensor did not drive the bus, so no error is flagged.
        err = (crc_calc != rx_byte) && (high_reg != BYTE_INVALID)
              && (low_reg != BYTE_INVALID) && (rx_byte != BYTE_INVALID);

        pos_next    = pos_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        sticky_next = sticky_reg;
        has_result  = 1'b0;
        unique case (pos_eff)
            POS_LOW: begin
                low_next = rx_byte;
                pos_next = POS_CRC;
            end
            POS_CRC: begin
                has_result  = 1'b1;
                sticky_next = sticky_eff | err;
                pos_next    = POS_HIGH;
            end
            default: begin
                high_next   = rx_byte;
                sticky_next = sticky_eff;
                pos_next    = POS_LOW;
            end
        endcase

        result.word_value  = {high_reg, low_reg};
        result.crc_value   = crc_calc;
        result.crc_error   = err;
        result.frame_error = sticky_eff | err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_HIGH;
            high_reg   <= 8'h00;
            low_reg    <= 8'h00;
            sticky_reg <= 1'b0;
        end else if (take) begin
            pos_reg    <= pos_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            sticky_reg <= sticky_next;
        end
    end

    a_crc_to_high: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !frame_start && pos_reg == POS_CRC |=> pos_reg == POS_HIGH)
        else $error("framer did not return to the high byte after a CRC byte");

    a_start_to_low: assert property (@(posedge aclk) disable iff (!aresetn)
        take && frame_start |=> pos_reg == POS_LOW && !sticky_reg)
        else $error("frame start did not restart the triplet and clear the error");

    a_low_to_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !frame_start && pos_reg == POS_LOW |=> pos_reg == POS_CRC)
        else $error("framer did not advance to the CRC byte");

    a_no_result_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        has_result |-> !frame_start)
        else $error("result raised on the first byte of a frame");

endmodule
